### rtl/i2c_register_access_master_defines.svh
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Concurrent check macros for the RTL top level; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check cons on the same edge as ante
`define I2CRAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check cons on the edge after ante
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CRAM_ASSERT_NOW(lbl, ante, cons, msg)
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - package
// Beat types, sequencer state, phase and stage codes, timing constants.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    // Command codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WRITE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_READ_ADDRESS  = 2'd1;
    localparam logic [1:0] CFG_ACK_TRIES     = 2'd2;

    localparam logic [3:0] ACK_TRIES_RESET = 4'd6;

    // Phase lengths in ticks
    localparam logic [4:0] LEN_ST_A  = 5'd3;
    localparam logic [4:0] LEN_ST_B  = 5'd10;
    localparam logic [4:0] LEN_ST_C  = 5'd10;
    localparam logic [4:0] LEN_PRE   = 5'd2;
    localparam logic [4:0] LEN_BIT   = 5'd1;
    localparam logic [4:0] LEN_ACK   = 5'd2;
    localparam logic [4:0] LEN_SA    = 5'd2;
    localparam logic [4:0] LEN_STP_A = 5'd3;
    localparam logic [4:0] LEN_STP_B = 5'd3;
    localparam logic [4:0] LEN_STP_C = 5'd20;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] LAST_BIT      = 4'd7;

    typedef enum logic [4:0] {
        P_IDLE     = 5'd0,
        P_ST_A     = 5'd1,
        P_ST_B     = 5'd2,
        P_ST_C     = 5'd3,
        P_WB_PRE   = 5'd4,
        P_WB_LO1   = 5'd5,
        P_WB_HI    = 5'd6,
        P_WB_LO2   = 5'd7,
        P_ACK_HI   = 5'd8,
        P_ACK_TAIL = 5'd9,
        P_STOP_A   = 5'd10,
        P_STOP_B   = 5'd11,
        P_STOP_C   = 5'd12,
        P_RB_HI    = 5'd13,
        P_RB_LO    = 5'd14,
        P_SA_A     = 5'd15,
        P_SA_B     = 5'd16,
        P_SA_C     = 5'd17
    } t_phase;

    typedef enum logic [2:0] {
        S_WADDR   = 3'd0,
        S_REG     = 3'd1,
        S_D1      = 3'd2,
        S_D2      = 3'd3,
        S_MIDSTOP = 3'd4,
        S_RADDR   = 3'd5,
        S_FINAL   = 3'd6
    } t_stage;

    typedef struct packed {
        logic [7:0] write_address;
        logic [7:0] read_address;
        logic [3:0] ack_tries;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  delay_left;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  bytes_left;
        logic [3:0]  tries_left;
        logic [7:0]  saved_register;
        logic [15:0] saved_data;
        logic        is_read;
        logic        write_two;
        logic        failed;
        t_stage      stage;
        logic        sda_latch;
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] wdata_first;
        logic [7:0] wdata_second;
        logic [1:0] write_count;
        logic [7:0] read_count;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl;
        logic       sda_level;
        logic       sda_driven;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic       status;
    } t_out;

endpackage

### rtl/i2cram_step.sv
// ----------------------------------------------------------------------------
// I2C register access master - tick sequencer
// Combinational step: bus levels and next state for one tick.
// ----------------------------------------------------------------------------
module i2cram_step (
    input  i2cram_pkg::t_state i_state,
    input  i2cram_pkg::t_cfg   i_cfg,
    input  i2cram_pkg::t_in    i_in,
    output i2cram_pkg::t_state o_state,
    output i2cram_pkg::t_out   o_out
);

    logic w_start;
    logic w_scl;
    logic w_lvl;
    logic w_drv;
    logic w_busy;
    logic w_rvalid;
    logic [7:0] w_rdata;
    logic w_rlast;
    logic w_done;
    logic w_status;
    i2cram_pkg::t_state n_state;

    function automatic i2cram_pkg::t_state f_enter(input i2cram_pkg::t_state st,
                                                   input i2cram_pkg::t_phase ph,
                                                   input logic [4:0] len);
        i2cram_pkg::t_state r;
        r            = st;
        r.phase      = ph;
        r.delay_left = len;
        return r;
    endfunction

    function automatic i2cram_pkg::t_state f_load(input i2cram_pkg::t_state st,
                                                  input logic [7:0] b);
        i2cram_pkg::t_state r;
        r            = st;
        r.shift_byte = b;
        r.bit_index  = '0;
        return f_enter(r, i2cram_pkg::P_WB_PRE, i2cram_pkg::LEN_PRE);
    endfunction

    function automatic i2cram_pkg::t_state f_final(input i2cram_pkg::t_state st);
        i2cram_pkg::t_state r;
        r       = st;
        r.stage = i2cram_pkg::S_FINAL;
        return f_enter(r, i2cram_pkg::P_STOP_A, i2cram_pkg::LEN_STP_A);
    endfunction

    function automatic i2cram_pkg::t_state f_read_begin(input i2cram_pkg::t_state st);
        i2cram_pkg::t_state r;
        r            = st;
        r.shift_byte = '0;
        r.bit_index  = '0;
        return f_enter(r, i2cram_pkg::P_RB_HI, i2cram_pkg::LEN_BIT);
    endfunction

    // Start of a command only from idle; func three counts as tick only
    assign w_start = (i_state.phase == i2cram_pkg::P_IDLE) &&
                     ((i_in.func == i2cram_pkg::FUNC_WRITE) ||
                      (i_in.func == i2cram_pkg::FUNC_READ));

    // Bus levels and result flags
    always_comb begin
        w_scl    = 1'b1;
        w_lvl    = 1'b1;
        w_drv    = 1'b1;
        w_busy   = 1'b0;
        w_rvalid = 1'b0;
        w_rdata  = '0;
        w_rlast  = 1'b0;
        w_done   = 1'b0;
        w_status = 1'b0;
        if (w_start) begin
            w_busy = 1'b1;
        end else if (i_state.phase != i2cram_pkg::P_IDLE) begin
            w_busy = 1'b1;
            unique case (i_state.phase)
                i2cram_pkg::P_ST_A: begin
                    w_scl = 1'b1;
                    w_lvl = 1'b1;
                end
                i2cram_pkg::P_ST_B: begin
                    w_scl = 1'b1;
                    w_lvl = 1'b0;
                end
                i2cram_pkg::P_ST_C, i2cram_pkg::P_STOP_A: begin
                    w_scl = 1'b0;
                    w_lvl = 1'b0;
                end
                i2cram_pkg::P_WB_LO1, i2cram_pkg::P_WB_LO2: begin
                    w_scl = 1'b0;
                    w_lvl = i_state.shift_byte[7];
                end
                i2cram_pkg::P_WB_HI: begin
                    w_scl = 1'b1;
                    w_lvl = i_state.shift_byte[7];
                end
                i2cram_pkg::P_ACK_HI: begin
                    w_scl = 1'b1;
                    w_drv = 1'b0;
                end
                i2cram_pkg::P_ACK_TAIL, i2cram_pkg::P_RB_LO: begin
                    w_scl = 1'b0;
                    w_drv = 1'b0;
                end
                i2cram_pkg::P_STOP_B: begin
                    w_scl = 1'b1;
                    w_lvl = 1'b0;
                end
                i2cram_pkg::P_STOP_C: begin
                    w_scl = 1'b1;
                    w_lvl = 1'b1;
                    if ((i_state.delay_left <= 5'd1) &&
                        (i_state.stage != i2cram_pkg::S_MIDSTOP)) begin
                        w_done   = 1'b1;
                        w_status = i_state.failed;
                    end
                end
                i2cram_pkg::P_RB_HI: begin
                    w_scl = 1'b1;
                    w_drv = 1'b0;
                    if (i_state.bit_index == i2cram_pkg::LAST_BIT) begin
                        w_rvalid = 1'b1;
                        w_rdata  = {i_state.shift_byte[6:0], i_in.sda_in};
                        w_rlast  = (i_state.bytes_left == 8'd1);
                    end
                end
                i2cram_pkg::P_SA_B: begin
                    w_scl = 1'b1;
                    w_lvl = i_state.sda_latch;
                end
                default: begin
                    w_scl = 1'b0;
                    w_lvl = i_state.sda_latch;
                end
            endcase
        end
    end

    always_comb begin
        o_out.scl        = w_scl;
        o_out.sda_level  = w_drv & w_lvl;
        o_out.sda_driven = w_drv;
        o_out.busy_res   = w_busy;
        o_out.read_valid = w_rvalid;
        o_out.read_data  = w_rdata;
        o_out.read_last  = w_rlast;
        o_out.done_res   = w_done;
        o_out.status     = w_status;
    end

    // Next state
    always_comb begin
        n_state = i_state;
        if (w_start) begin
            n_state.saved_register = i_in.reg_addr;
            n_state.saved_data     = {i_in.wdata_first, i_in.wdata_second};
            n_state.write_two      = (i_in.write_count == 2'd2);
            n_state.is_read        = (i_in.func == i2cram_pkg::FUNC_READ);
            n_state.bytes_left     = (i_in.func == i2cram_pkg::FUNC_READ) ?
                                     i_in.read_count : 8'd0;
            n_state.failed         = 1'b0;
            n_state.stage          = i2cram_pkg::S_WADDR;
            n_state.sda_latch      = 1'b1;
            n_state.phase          = i2cram_pkg::P_ST_A;
            n_state.delay_left     = i2cram_pkg::LEN_ST_A - 5'd1;
        end else if (i_state.phase != i2cram_pkg::P_IDLE) begin
            if (w_drv) begin
                n_state.sda_latch = w_lvl;
            end
            if (i_state.delay_left > 5'd1) begin
                n_state.delay_left = i_state.delay_left - 5'd1;
            end else begin
                unique case (i_state.phase)
                    i2cram_pkg::P_ST_A:
                        n_state = f_enter(n_state, i2cram_pkg::P_ST_B, i2cram_pkg::LEN_ST_B);
                    i2cram_pkg::P_ST_B:
                        n_state = f_enter(n_state, i2cram_pkg::P_ST_C, i2cram_pkg::LEN_ST_C);
                    i2cram_pkg::P_ST_C: begin
                        if (i_state.stage == i2cram_pkg::S_MIDSTOP) begin
                            n_state.stage = i2cram_pkg::S_RADDR;
                            n_state       = f_load(n_state, i_cfg.read_address);
                        end else begin
                            n_state.stage = i2cram_pkg::S_WADDR;
                            n_state       = f_load(n_state, i_cfg.write_address);
                        end
                    end
                    i2cram_pkg::P_WB_PRE:
                        n_state = f_enter(n_state, i2cram_pkg::P_WB_LO1, i2cram_pkg::LEN_BIT);
                    i2cram_pkg::P_WB_LO1:
                        n_state = f_enter(n_state, i2cram_pkg::P_WB_HI, i2cram_pkg::LEN_BIT);
                    i2cram_pkg::P_WB_HI:
                        n_state = f_enter(n_state, i2cram_pkg::P_WB_LO2, i2cram_pkg::LEN_BIT);
                    i2cram_pkg::P_WB_LO2: begin
                        n_state.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                        n_state.bit_index  = i_state.bit_index + 4'd1;
                        if (n_state.bit_index >= i2cram_pkg::BITS_PER_BYTE) begin
                            n_state.tries_left = i_cfg.ack_tries;
                            if (i_cfg.ack_tries == 4'd0) begin
                                n_state.failed = 1'b1;
                                n_state = f_enter(n_state, i2cram_pkg::P_ACK_TAIL,
                                                  i2cram_pkg::LEN_ACK);
                            end else begin
                                n_state = f_enter(n_state, i2cram_pkg::P_ACK_HI,
                                                  i2cram_pkg::LEN_ACK);
                            end
                        end else begin
                            n_state = f_enter(n_state, i2cram_pkg::P_WB_LO1,
                                              i2cram_pkg::LEN_BIT);
                        end
                    end
                    i2cram_pkg::P_ACK_HI: begin
                        if (!i_in.sda_in) begin
                            n_state = f_enter(n_state, i2cram_pkg::P_ACK_TAIL,
                                              i2cram_pkg::LEN_ACK);
                        end else begin
                            n_state.tries_left = i_state.tries_left - 4'd1;
                            if (i_state.tries_left == 4'd1) begin
                                n_state.failed = 1'b1;
                                n_state = f_enter(n_state, i2cram_pkg::P_ACK_TAIL,
                                                  i2cram_pkg::LEN_ACK);
                            end else begin
                                n_state = f_enter(n_state, i2cram_pkg::P_ACK_HI,
                                                  i2cram_pkg::LEN_ACK);
                            end
                        end
                    end
                    i2cram_pkg::P_ACK_TAIL: begin
                        if (i_state.failed) begin
                            n_state = f_final(n_state);
                        end else begin
                            case (i_state.stage)
                                i2cram_pkg::S_WADDR: begin
                                    n_state.stage = i2cram_pkg::S_REG;
                                    n_state = f_load(n_state, i_state.saved_register);
                                end
                                i2cram_pkg::S_REG: begin
                                    if (i_state.is_read) begin
                                        n_state.stage = i2cram_pkg::S_MIDSTOP;
                                        n_state = f_enter(n_state, i2cram_pkg::P_STOP_A,
                                                          i2cram_pkg::LEN_STP_A);
                                    end else begin
                                        n_state.stage = i2cram_pkg::S_D1;
                                        n_state = f_load(n_state, i_state.saved_data[15:8]);
                                    end
                                end
                                i2cram_pkg::S_D1: begin
                                    if (i_state.write_two) begin
                                        n_state.stage = i2cram_pkg::S_D2;
                                        n_state = f_load(n_state, i_state.saved_data[7:0]);
                                    end else begin
                                        n_state = f_final(n_state);
                                    end
                                end
                                i2cram_pkg::S_RADDR: begin
                                    if (i_state.bytes_left == 8'd0) begin
                                        n_state = f_final(n_state);
                                    end else begin
                                        n_state = f_read_begin(n_state);
                                    end
                                end
                                default: n_state = f_final(n_state);
                            endcase
                        end
                    end
                    i2cram_pkg::P_STOP_A:
                        n_state = f_enter(n_state, i2cram_pkg::P_STOP_B, i2cram_pkg::LEN_STP_B);
                    i2cram_pkg::P_STOP_B:
                        n_state = f_enter(n_state, i2cram_pkg::P_STOP_C, i2cram_pkg::LEN_STP_C);
                    i2cram_pkg::P_STOP_C: begin
                        if (i_state.stage == i2cram_pkg::S_MIDSTOP) begin
                            n_state = f_enter(n_state, i2cram_pkg::P_ST_A, i2cram_pkg::LEN_ST_A);
                        end else begin
                            n_state = f_enter(n_state, i2cram_pkg::P_IDLE, 5'd0);
                        end
                    end
                    i2cram_pkg::P_RB_HI: begin
                        n_state.shift_byte = {i_state.shift_byte[6:0], i_in.sda_in};
                        n_state.bit_index  = i_state.bit_index + 4'd1;
                        n_state = f_enter(n_state, i2cram_pkg::P_RB_LO, i2cram_pkg::LEN_BIT);
                    end
                    i2cram_pkg::P_RB_LO: begin
                        if (i_state.bit_index >= i2cram_pkg::BITS_PER_BYTE) begin
                            n_state.sda_latch = (i_state.bytes_left == 8'd1);
                            n_state = f_enter(n_state, i2cram_pkg::P_SA_A, i2cram_pkg::LEN_SA);
                        end else begin
                            n_state = f_enter(n_state, i2cram_pkg::P_RB_HI, i2cram_pkg::LEN_BIT);
                        end
                    end
                    i2cram_pkg::P_SA_A:
                        n_state = f_enter(n_state, i2cram_pkg::P_SA_B, i2cram_pkg::LEN_SA);
                    i2cram_pkg::P_SA_B:
                        n_state = f_enter(n_state, i2cram_pkg::P_SA_C, i2cram_pkg::LEN_SA);
                    i2cram_pkg::P_SA_C: begin
                        n_state.bytes_left = i_state.bytes_left - 8'd1;
                        if (i_state.bytes_left == 8'd1) begin
                            n_state = f_final(n_state);
                        end else begin
                            n_state = f_read_begin(n_state);
                        end
                    end
                    default:
                        n_state = f_enter(n_state, i2cram_pkg::P_IDLE, 5'd0);
                endcase
            end
        end
    end

    assign o_state = n_state;

endmodule

### rtl/i2cram_obuf.sv
// ----------------------------------------------------------------------------
// I2C register access master - result register
// Hold one result beat; free again once the beat is taken.
// ----------------------------------------------------------------------------
module i2cram_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  i2cram_pkg::t_out i_data,
    output logic             o_free,
    output logic             o_valid,
    output i2cram_pkg::t_out o_data,
    input  logic             i_ready
);

    logic             r_valid;
    i2cram_pkg::t_out r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Tick-driven I2C master for register writes and reads with acknowledge checks.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick (one delay unit) and yields exactly one result
// beat carrying the SCL/SDA levels for that tick plus read, done and status flags.
// The block takes one beat per clock: the sequencer state updates in the same
// cycle as the beat is accepted and the result lands in a single output register,
// so a new beat is accepted whenever that register is empty or being drained.
// Start a write or a read by presenting func WRITE or READ while the sequencer
// is idle; commands seen while busy are ignored and the beat counts as a tick.
// A read sends the register phase, a full stop and a fresh start, then the read
// address, and streams bytes with read_valid on the tick sampling the last bit.
// Write the configuration registers only while no transaction is running.
// There is no memory and no post-reset clearing pass.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_defines.svh"

module i2c_register_access_master (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Tick / command channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  i2cram_pkg::t_in  i_in_data,
    // Result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output i2cram_pkg::t_out o_out_data,
    // Configuration writes
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_wdata
);

    i2cram_pkg::t_state r_state;
    i2cram_pkg::t_state n_state;
    i2cram_pkg::t_cfg   r_cfg;
    i2cram_pkg::t_out   w_result;
    logic               w_free;
    logic               w_fire;

    // Accept a tick whenever the result register can take its beat
    assign o_in_ready = w_free;
    assign w_fire     = i_in_valid && w_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_address <= '0;
            r_cfg.read_address  <= '0;
            r_cfg.ack_tries     <= i2cram_pkg::ACK_TRIES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cram_pkg::CFG_WRITE_ADDRESS: r_cfg.write_address <= i_cfg_wdata;
                i2cram_pkg::CFG_READ_ADDRESS:  r_cfg.read_address  <= i_cfg_wdata;
                i2cram_pkg::CFG_ACK_TRIES:     r_cfg.ack_tries     <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Sequencer state advances only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= i2cram_pkg::P_IDLE;
            r_state.delay_left     <= '0;
            r_state.bit_index      <= '0;
            r_state.shift_byte     <= '0;
            r_state.bytes_left     <= '0;
            r_state.tries_left     <= '0;
            r_state.saved_register <= '0;
            r_state.saved_data     <= '0;
            r_state.is_read        <= 1'b0;
            r_state.write_two      <= 1'b0;
            r_state.failed         <= 1'b0;
            r_state.stage          <= i2cram_pkg::S_WADDR;
            r_state.sda_latch      <= 1'b1;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    i2cram_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_in    (i_in_data),
        .o_state (n_state),
        .o_out   (w_result)
    );

    i2cram_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_data  (w_result),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

    // A busy phase always has time left to run
    `I2CRAM_ASSERT_NOW(a_delay_nonzero, r_state.phase != i2cram_pkg::P_IDLE, r_state.delay_left != 5'd0, "busy phase with zero delay")
    // Never overwrite a stalled result beat
    `I2CRAM_ASSERT_NOW(a_no_overwrite, o_out_valid && !i_out_ready, !o_in_ready, "input taken while result stalled")
    // A command from idle shows up as a busy start tick
    `I2CRAM_ASSERT_NEXT(a_cmd_starts, w_fire && (r_state.phase == i2cram_pkg::P_IDLE) && ((i_in_data.func == i2cram_pkg::FUNC_WRITE) || (i_in_data.func == i2cram_pkg::FUNC_READ)), o_out_valid && o_out_data.busy_res && o_out_data.scl, "command did not start")
    // Read bytes are sampled with SCL high and SDA released
    `I2CRAM_ASSERT_NOW(a_read_bus, o_out_valid && o_out_data.read_valid, o_out_data.scl && !o_out_data.sda_driven, "read byte outside SCL high")
    // Status only means something alongside done
    `I2CRAM_ASSERT_NOW(a_status_done, o_out_valid && !o_out_data.done_res, !o_out_data.status, "status without done")

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// I2C register access master - regression bench
// Drives bus ticks and commands through the valid/ready channels, predicts the
// SCL/SDA levels and read/done flags of every tick, and checks each result beat.
// ----------------------------------------------------------------------------
module tb_top;

    // Func code 3 carries no command; the sequencer treats it as a plain tick
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    // Cycles without any handshake or register write before the run is abandoned
    localparam int QUIET_LIMIT = 4000;
    // Mismatch lines printed before further reports are suppressed
    localparam int REPORT_CAP = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    i2cram_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    i2cram_pkg::t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_wdata = '0;

    i2c_register_access_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bus sequencer prediction
    // ------------------------------------------------------------------------
    // Shadow copy of the sequencer and of its registers, kept in step with the
    // beats that the block accepts.
    i2cram_pkg::t_state seq;
    i2cram_pkg::t_cfg   cfg;

    i2cram_pkg::t_in  tick_q[$];      // beats waiting for the driver
    i2cram_pkg::t_out bus_exp_q[$];   // predicted bus levels and flags, oldest first

    int ticks_pushed = 0;
    int ticks_taken  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    logic beat_taken = 1'b0;

    initial begin
        seq = '0;
        seq.phase = i2cram_pkg::P_IDLE;
        seq.stage = i2cram_pkg::S_WADDR;
        seq.sda_latch = 1'b1;
        cfg = '0;
        cfg.ack_tries = i2cram_pkg::ACK_TRIES_RESET;
    end

    function automatic void go(i2cram_pkg::t_phase ph, logic [4:0] len);
        seq.phase = ph;
        seq.delay_left = len;
    endfunction

    function automatic void send_byte(logic [7:0] b);
        seq.shift_byte = b;
        seq.bit_index = '0;
        go(i2cram_pkg::P_WB_PRE, i2cram_pkg::LEN_PRE);
    endfunction

    function automatic void close_bus();
        seq.stage = i2cram_pkg::S_FINAL;
        go(i2cram_pkg::P_STOP_A, i2cram_pkg::LEN_STP_A);
    endfunction

    function automatic void open_read_byte();
        seq.shift_byte = '0;
        seq.bit_index = '0;
        go(i2cram_pkg::P_RB_HI, i2cram_pkg::LEN_BIT);
    endfunction

    // Move to the next phase once the current one has run its length
    function automatic void advance_phase(logic sda);
        case (seq.phase)
            i2cram_pkg::P_ST_A: go(i2cram_pkg::P_ST_B, i2cram_pkg::LEN_ST_B);
            i2cram_pkg::P_ST_B: go(i2cram_pkg::P_ST_C, i2cram_pkg::LEN_ST_C);
            i2cram_pkg::P_ST_C: begin
                // A start after the mid stop addresses the device for reading
                if (seq.stage == i2cram_pkg::S_MIDSTOP) begin
                    seq.stage = i2cram_pkg::S_RADDR;
                    send_byte(cfg.read_address);
                end else begin
                    seq.stage = i2cram_pkg::S_WADDR;
                    send_byte(cfg.write_address);
                end
            end
            i2cram_pkg::P_WB_PRE: go(i2cram_pkg::P_WB_LO1, i2cram_pkg::LEN_BIT);
            i2cram_pkg::P_WB_LO1: go(i2cram_pkg::P_WB_HI, i2cram_pkg::LEN_BIT);
            i2cram_pkg::P_WB_HI:  go(i2cram_pkg::P_WB_LO2, i2cram_pkg::LEN_BIT);
            i2cram_pkg::P_WB_LO2: begin
                seq.shift_byte = {seq.shift_byte[6:0], 1'b0};
                seq.bit_index = seq.bit_index + 4'd1;
                if (seq.bit_index >= i2cram_pkg::BITS_PER_BYTE) begin
                    seq.tries_left = cfg.ack_tries;
                    // No tries at all counts as a missing acknowledge
                    if (seq.tries_left == 4'd0) begin
                        seq.failed = 1'b1;
                        go(i2cram_pkg::P_ACK_TAIL, i2cram_pkg::LEN_ACK);
                    end else begin
                        go(i2cram_pkg::P_ACK_HI, i2cram_pkg::LEN_ACK);
                    end
                end else begin
                    go(i2cram_pkg::P_WB_LO1, i2cram_pkg::LEN_BIT);
                end
            end
            i2cram_pkg::P_ACK_HI: begin
                if (sda == 1'b0) begin
                    go(i2cram_pkg::P_ACK_TAIL, i2cram_pkg::LEN_ACK);
                end else begin
                    seq.tries_left = seq.tries_left - 4'd1;
                    if (seq.tries_left == 4'd0) begin
                        seq.failed = 1'b1;
                        go(i2cram_pkg::P_ACK_TAIL, i2cram_pkg::LEN_ACK);
                    end else begin
                        go(i2cram_pkg::P_ACK_HI, i2cram_pkg::LEN_ACK);
                    end
                end
            end
            i2cram_pkg::P_ACK_TAIL: begin
                if (seq.failed) begin
                    close_bus();
                end else begin
                    case (seq.stage)
                        i2cram_pkg::S_WADDR: begin
                            seq.stage = i2cram_pkg::S_REG;
                            send_byte(seq.saved_register);
                        end
                        i2cram_pkg::S_REG: begin
                            // Reads close the register phase with a full stop
                            if (seq.is_read) begin
                                seq.stage = i2cram_pkg::S_MIDSTOP;
                                go(i2cram_pkg::P_STOP_A, i2cram_pkg::LEN_STP_A);
                            end else begin
                                seq.stage = i2cram_pkg::S_D1;
                                send_byte(seq.saved_data[15:8]);
                            end
                        end
                        i2cram_pkg::S_D1: begin
                            if (seq.write_two) begin
                                seq.stage = i2cram_pkg::S_D2;
                                send_byte(seq.saved_data[7:0]);
                            end else begin
                                close_bus();
                            end
                        end
                        i2cram_pkg::S_RADDR: begin
                            if (seq.bytes_left == 8'd0) close_bus();
                            else open_read_byte();
                        end
                        default: close_bus();
                    endcase
                end
            end
            i2cram_pkg::P_STOP_A: go(i2cram_pkg::P_STOP_B, i2cram_pkg::LEN_STP_B);
            i2cram_pkg::P_STOP_B: go(i2cram_pkg::P_STOP_C, i2cram_pkg::LEN_STP_C);
            i2cram_pkg::P_STOP_C: begin
                if (seq.stage == i2cram_pkg::S_MIDSTOP) go(i2cram_pkg::P_ST_A, i2cram_pkg::LEN_ST_A);
                else go(i2cram_pkg::P_IDLE, 5'd0);
            end
            i2cram_pkg::P_RB_HI: begin
                seq.shift_byte = {seq.shift_byte[6:0], sda};
                seq.bit_index = seq.bit_index + 4'd1;
                go(i2cram_pkg::P_RB_LO, i2cram_pkg::LEN_BIT);
            end
            i2cram_pkg::P_RB_LO: begin
                if (seq.bit_index >= i2cram_pkg::BITS_PER_BYTE) begin
                    // Acknowledge every byte but the last, which gets a high bit
                    seq.sda_latch = (seq.bytes_left == 8'd1);
                    go(i2cram_pkg::P_SA_A, i2cram_pkg::LEN_SA);
                end else begin
                    go(i2cram_pkg::P_RB_HI, i2cram_pkg::LEN_BIT);
                end
            end
            i2cram_pkg::P_SA_A: go(i2cram_pkg::P_SA_B, i2cram_pkg::LEN_SA);
            i2cram_pkg::P_SA_B: go(i2cram_pkg::P_SA_C, i2cram_pkg::LEN_SA);
            i2cram_pkg::P_SA_C: begin
                seq.bytes_left = seq.bytes_left - 8'd1;
                if (seq.bytes_left == 8'd0) close_bus();
                else open_read_byte();
            end
            default: go(i2cram_pkg::P_IDLE, 5'd0);
        endcase
    endfunction

    // Work out the bus levels and flags of one tick and step the shadow sequencer
    function automatic i2cram_pkg::t_out predict_bus_tick(i2cram_pkg::t_in beat);
        i2cram_pkg::t_out r;
        logic lvl;
        logic drv;
        r = '0;
        r.scl = 1'b1;
        lvl = 1'b1;
        drv = 1'b1;
        // Commands only take effect while idle; otherwise the beat is a tick
        if (seq.phase == i2cram_pkg::P_IDLE &&
            (beat.func == i2cram_pkg::FUNC_WRITE || beat.func == i2cram_pkg::FUNC_READ)) begin
            seq.saved_register = beat.reg_addr;
            seq.saved_data = {beat.wdata_first, beat.wdata_second};
            seq.write_two = (beat.write_count == 2'd2);
            seq.is_read = (beat.func == i2cram_pkg::FUNC_READ);
            seq.bytes_left = (beat.func == i2cram_pkg::FUNC_READ) ? beat.read_count : 8'd0;
            seq.failed = 1'b0;
            seq.stage = i2cram_pkg::S_WADDR;
            go(i2cram_pkg::P_ST_A, i2cram_pkg::LEN_ST_A);
        end
        if (seq.phase != i2cram_pkg::P_IDLE) begin
            r.busy_res = 1'b1;
            case (seq.phase)
                i2cram_pkg::P_ST_A: begin
                    r.scl = 1'b1;
                    lvl = 1'b1;
                end
                i2cram_pkg::P_ST_B: begin
                    r.scl = 1'b1;
                    lvl = 1'b0;
                end
                i2cram_pkg::P_ST_C, i2cram_pkg::P_STOP_A: begin
                    r.scl = 1'b0;
                    lvl = 1'b0;
                end
                i2cram_pkg::P_WB_PRE: begin
                    r.scl = 1'b0;
                    lvl = seq.sda_latch;
                end
                i2cram_pkg::P_WB_LO1, i2cram_pkg::P_WB_LO2: begin
                    r.scl = 1'b0;
                    lvl = seq.shift_byte[7];
                end
                i2cram_pkg::P_WB_HI: begin
                    r.scl = 1'b1;
                    lvl = seq.shift_byte[7];
                end
                i2cram_pkg::P_ACK_HI: begin
                    r.scl = 1'b1;
                    drv = 1'b0;
                end
                i2cram_pkg::P_ACK_TAIL, i2cram_pkg::P_RB_LO: begin
                    r.scl = 1'b0;
                    drv = 1'b0;
                end
                i2cram_pkg::P_STOP_B: begin
                    r.scl = 1'b1;
                    lvl = 1'b0;
                end
                i2cram_pkg::P_STOP_C: begin
                    r.scl = 1'b1;
                    lvl = 1'b1;
                    // The stop between register and read phases reports nothing
                    if (seq.delay_left <= 5'd1 && seq.stage != i2cram_pkg::S_MIDSTOP) begin
                        r.done_res = 1'b1;
                        r.status = seq.failed;
                    end
                end
                i2cram_pkg::P_RB_HI: begin
                    r.scl = 1'b1;
                    drv = 1'b0;
                    if (seq.bit_index == i2cram_pkg::LAST_BIT) begin
                        r.read_valid = 1'b1;
                        r.read_data = {seq.shift_byte[6:0], beat.sda_in};
                        r.read_last = (seq.bytes_left == 8'd1);
                    end
                end
                i2cram_pkg::P_SA_B: begin
                    r.scl = 1'b1;
                    lvl = seq.sda_latch;
                end
                default: begin
                    r.scl = 1'b0;
                    lvl = seq.sda_latch;
                end
            endcase
            if (drv) seq.sda_latch = lvl;
            if (seq.delay_left > 5'd1) seq.delay_left = seq.delay_left - 5'd1;
            else advance_phase(beat.sda_in);
        end
        r.sda_driven = drv;
        r.sda_level = drv ? lvl : 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver and sink, both on the falling edge
    // ------------------------------------------------------------------------
    // Hold the beat until it is taken, then offer the next one unless the
    // sender is told to idle this cycle. Roll the sink's ready every cycle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= tick_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog, on the rising edge
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        i2cram_pkg::t_out want;
        beat_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            // Compare before predicting: a result never belongs to this edge's beat
            if (o_out_valid && i_out_ready) begin
                if (bus_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result beat with nothing expected, expected none, actual %h",
                                 $time, o_out_data);
                end else begin
                    want = bus_exp_q.pop_front();
                    check_field("scl", 8'(want.scl), 8'(o_out_data.scl));
                    check_field("sda_level", 8'(want.sda_level), 8'(o_out_data.sda_level));
                    check_field("sda_driven", 8'(want.sda_driven), 8'(o_out_data.sda_driven));
                    check_field("busy_res", 8'(want.busy_res), 8'(o_out_data.busy_res));
                    check_field("read_valid", 8'(want.read_valid), 8'(o_out_data.read_valid));
                    check_field("read_data", want.read_data, o_out_data.read_data);
                    check_field("read_last", 8'(want.read_last), 8'(o_out_data.read_last));
                    check_field("done_res", 8'(want.done_res), 8'(o_out_data.done_res));
                    check_field("status", 8'(want.status), 8'(o_out_data.status));
                end
            end
            if (i_in_valid && o_in_ready) begin
                bus_exp_q.push_back(predict_bus_tick(i_in_data));
                ticks_taken++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("i2c_register_access_master regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic i2cram_pkg::t_in random_beat(logic [1:0] f, logic s);
        i2cram_pkg::t_in b;
        b.func = f;
        b.reg_addr = 8'($urandom_range(255));
        b.wdata_first = 8'($urandom_range(255));
        b.wdata_second = 8'($urandom_range(255));
        b.write_count = 2'($urandom_range(3));
        b.read_count = 8'($urandom_range(255));
        b.sda_in = s;
        return b;
    endfunction

    task automatic queue_beat(input i2cram_pkg::t_in b);
        tick_q.push_back(b);
        ticks_pushed++;
    endtask

    // Hold until every queued beat has been taken and every result has come
    task automatic wait_bus_quiet();
        do @(negedge i_clk);
        while (ticks_taken != ticks_pushed || bus_exp_q.size() != 0);
    endtask

    // Write all three registers while the sequencer sits idle
    task automatic configure(input logic [7:0] wa, input logic [7:0] ra, input logic [3:0] tries);
        logic [7:0] vals[3];
        logic [1:0] idxs[3];
        vals = '{wa, ra, {4'd0, tries}};
        idxs = '{i2cram_pkg::CFG_WRITE_ADDRESS, i2cram_pkg::CFG_READ_ADDRESS,
                 i2cram_pkg::CFG_ACK_TRIES};
        wait_bus_quiet();
        for (int k = 0; k < 3; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            case (idxs[k])
                i2cram_pkg::CFG_WRITE_ADDRESS: cfg.write_address = vals[k];
                i2cram_pkg::CFG_READ_ADDRESS:  cfg.read_address = vals[k];
                i2cram_pkg::CFG_ACK_TRIES:     cfg.ack_tries = vals[k][3:0];
                default: ;
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
        end
    endtask

    // Issue one command from idle, then feed ticks until the sequencer is idle
    // again. The slave pulls SDA low with ack_pct percent odds outside read
    // bits; read bits are fair coin flips. Stray commands land only where the
    // sequencer cannot finish before they arrive, so they are always ignored.
    task automatic do_transfer(input logic [1:0] func, input logic [7:0] reg_a,
                               input logic [7:0] d1, input logic [7:0] d2,
                               input logic [1:0] wc, input logic [7:0] rc,
                               input int ack_pct, input int stray_pct);
        i2cram_pkg::t_in cmd;
        logic [1:0] f;
        logic s;
        repeat ($urandom_range(3))
            queue_beat(random_beat($urandom_range(1) ? FUNC_SPARE : i2cram_pkg::FUNC_TICK,
                                   1'($urandom_range(1))));
        cmd = random_beat(func, 1'($urandom_range(1)));
        cmd.reg_addr = reg_a;
        cmd.wdata_first = d1;
        cmd.wdata_second = d2;
        cmd.write_count = wc;
        cmd.read_count = rc;
        queue_beat(cmd);
        while (!(ticks_taken == ticks_pushed && seq.phase == i2cram_pkg::P_IDLE)) begin
            @(negedge i_clk);
            // Keep the prediction at most three beats behind the queue
            if (ticks_pushed - ticks_taken < 3) begin
                if (seq.phase != i2cram_pkg::P_IDLE && seq.phase != i2cram_pkg::P_STOP_C &&
                    $urandom_range(99) < stray_pct)
                    f = 2'($urandom_range(3, 1));
                else
                    f = ($urandom_range(19) == 0) ? FUNC_SPARE : i2cram_pkg::FUNC_TICK;
                if (seq.phase == i2cram_pkg::P_RB_HI || seq.phase == i2cram_pkg::P_RB_LO)
                    s = 1'($urandom_range(1));
                else
                    s = ($urandom_range(99) >= ack_pct);
                queue_beat(random_beat(f, s));
                // Now and then drop the sender until the sink has caught up
                if ($urandom_range(299) == 0) wait_bus_quiet();
            end
        end
    endtask

    initial begin : stimulus
        int phase_base;
        logic [7:0] rc;
        int ack_pct;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the registers at their reset values
        do_transfer(i2cram_pkg::FUNC_READ, 8'h3C, 8'h00, 8'hFF, 2'd2, 8'd2, 100, 0);
        configure(8'hFF, 8'h00, 4'd15);
        // Silent slave: the write address is never acknowledged
        do_transfer(i2cram_pkg::FUNC_WRITE, 8'hFF, 8'h00, 8'hFF, 2'd2, 8'd0, 0, 0);
        // Single data byte for any count other than two; commands while busy
        do_transfer(i2cram_pkg::FUNC_WRITE, 8'h5A, 8'hA5, 8'h5A, 2'd0, 8'hFF, 90, 30);
        // Zero-length read: stop straight after the read address
        do_transfer(i2cram_pkg::FUNC_READ, 8'h01, 8'h00, 8'h00, 2'd1, 8'd0, 100, 0);
        configure(8'h00, 8'hFF, 4'd1);
        // One acknowledge sample per byte
        do_transfer(i2cram_pkg::FUNC_WRITE, 8'h7F, 8'h01, 8'hFE, 2'd2, 8'd1, 50, 0);
        configure(8'h5A, 8'hA5, 4'd0);
        // No acknowledge samples at all: the first acknowledge counts as missing
        do_transfer(i2cram_pkg::FUNC_READ, 8'hC3, 8'h00, 8'h00, 2'd2, 8'd1, 100, 0);

        // Random part, one block per idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            wait_bus_quiet();
            case (ph)
                0: configure(8'($urandom_range(255)), 8'($urandom_range(255)), 4'd15);
                1: configure(8'h00, 8'hFF, 4'd1);
                2: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                             4'($urandom_range(15, 1)));
                default: configure(8'hFF, 8'h00, 4'd3);
            endcase
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 74;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    sink_stall_pct = 74;
                end
                default: begin
                    send_idle_pct = 24;
                    sink_stall_pct = 24;
                end
            endcase
            phase_base = ticks_pushed;
            while (ticks_pushed - phase_base < 100) begin
                case ($urandom_range(19))
                    0:       rc = 8'd0;
                    1, 2:    rc = 8'($urandom_range(16, 5));
                    default: rc = 8'($urandom_range(4, 1));
                endcase
                case ($urandom_range(7))
                    0:       ack_pct = 0;
                    1:       ack_pct = 40;
                    2, 3:    ack_pct = 80;
                    default: ack_pct = 95;
                endcase
                do_transfer($urandom_range(1) ? i2cram_pkg::FUNC_WRITE : i2cram_pkg::FUNC_READ,
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 2'($urandom_range(3)),
                            rc, ack_pct, 5);
            end
        end

        // Drain, allow the output register to settle, then report
        wait_bus_quiet();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && bus_exp_q.size() == 0)
            $display("i2c_register_access_master regression: pass");
        else
            $display("i2c_register_access_master regression: fail");
        $finish;
    end

endmodule
